// ===== sv/bilinear_upsample_2x_assert.svh =====
// Assertion macros for the bilinear 2x upsampler.
// Each use needs clk and rst_n in scope. No other dependencies.
`ifndef BILINEAR_UPSAMPLE_2X_ASSERT_SVH
`define BILINEAR_UPSAMPLE_2X_ASSERT_SVH

// The consequence must hold in the same cycle as the antecedent.
`define BLUP2X_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequence must hold in the cycle after the antecedent.
`define BLUP2X_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/blup2x_pkg.sv =====
// Shared constants, types and helper functions for the bilinear 2x upsampler.
// This package has no dependencies. Every module of the block imports it.
`timescale 1ns / 1ps

package blup2x_pkg;

  // Largest coarse grid side that the line buffer holds.
  localparam int MAX_COARSE  = 512;
  localparam int POS_W       = (MAX_COARSE > 1) ? $clog2(MAX_COARSE) : 1;
  localparam int SIZE_W      = $clog2(MAX_COARSE + 1);

  // Field widths fixed by the interface.
  localparam int CFG_W       = 10;
  localparam int SAMPLE_W    = 16;
  localparam int VALUE_W     = 18;
  localparam int FINE_W      = 10;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;
  localparam int RESET_SIZE  = 256;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [VALUE_W-1:0]  value_t;
  typedef logic [POS_W-1:0]           pos_t;
  typedef logic [SIZE_W-1:0]          size_t;
  typedef logic [FINE_W-1:0]          fine_t;

  // The four coarse cells a sample can complete, in emission order.
  typedef enum logic [1:0] {
    CELL_INNER  = 2'd0,
    CELL_RIGHT  = 2'd1,
    CELL_BOTTOM = 2'd2,
    CELL_CORNER = 2'd3
  } cell_t;

  // The four fine points of one cell, in emission order.
  typedef enum logic [1:0] {
    SUB_EVEN_EVEN = 2'd0,
    SUB_EVEN_ODD  = 2'd1,
    SUB_ODD_EVEN  = 2'd2,
    SUB_ODD_ODD   = 2'd3
  } sub_t;

  // Everything the emitter needs to produce the results of one sample.
  typedef struct packed {
    sample_t    ul;
    sample_t    up;
    sample_t    left;
    sample_t    cur;
    pos_t       row;
    pos_t       col;
    logic [3:0] mask;
  } cell_job_t;

  // Clamp the written side length into the supported range.
  function automatic size_t eff_size(input logic [CFG_W-1:0] cfg);
    if (cfg == '0) begin
      return size_t'(1);
    end else if (32'(cfg) > MAX_COARSE) begin
      return size_t'(MAX_COARSE);
    end else begin
      return size_t'(cfg);
    end
  endfunction

  // Fine coordinate 2*pos + odd, kept to the output width.
  function automatic fine_t fine_coord(input pos_t pos, input logic odd);
    logic [POS_W:0] full;
    full = {pos, odd};
    return fine_t'(full);
  endfunction

endpackage

// ===== sv/blup2x_row_mem.sv =====
// Line buffer holding the previous coarse row, one sample per column.
// Synchronous, read-first, with a registered read port. Depends on blup2x_pkg.
`timescale 1ns / 1ps

module blup2x_row_mem
  import blup2x_pkg::*;
(
  input  logic    clk,
  input  logic    en,
  input  pos_t    addr,
  input  sample_t wr_data,
  output sample_t rd_data
);

  sample_t mem [MAX_COARSE];
  sample_t rd_data_r;

  // Read the old entry and write the new sample in the same access.
  always_ff @(posedge clk) begin
    if (en) begin
      rd_data_r  <= mem[addr];
      mem[addr]  <= wr_data;
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/blup2x_cell_emit.sv =====
// Result sequencer: walks the completed cells of one sample and emits one
// fine value per unstalled cycle into a registered output stage. Depends on blup2x_pkg.
`timescale 1ns / 1ps

module blup2x_cell_emit
  import blup2x_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   job_load,
  input  cell_job_t              job_in,
  output logic                   job_ready,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  output logic                   out_tuser
);

  cell_job_t job_r;
  logic      job_valid_r;
  cell_t     cell_r;
  sub_t      sub_r;

  logic      out_valid_r;
  value_t    out_value_r;
  fine_t     out_row_r;
  fine_t     out_col_r;
  logic      out_last_r;
  logic      out_frame_r;

  logic [3:0] higher;
  cell_t      next_cell;
  cell_t      first_cell;
  logic       last_sub;
  logic       job_end;
  logic       go;
  sample_t    sa, sb, sc, sd;
  value_t     ea, eb, ec, ed;
  value_t     value;
  pos_t       cell_row;
  pos_t       cell_col;
  logic       row_odd;
  logic       col_odd;
  sub_t       sub_nxt;

  // Cells still pending after the current one.
  always_comb begin
    unique case (cell_r)
      CELL_INNER:  higher = job_r.mask & 4'b1110;
      CELL_RIGHT:  higher = job_r.mask & 4'b1100;
      CELL_BOTTOM: higher = job_r.mask & 4'b1000;
      CELL_CORNER: higher = 4'b0000;
      default:     higher = 4'b0000;
    endcase
  end

  // Lowest pending cell above the current one.
  always_comb begin
    priority if (higher[1]) begin
      next_cell = CELL_RIGHT;
    end else if (higher[2]) begin
      next_cell = CELL_BOTTOM;
    end else begin
      next_cell = CELL_CORNER;
    end
  end

  // First cell of an incoming job.
  always_comb begin
    priority if (job_in.mask[0]) begin
      first_cell = CELL_INNER;
    end else if (job_in.mask[1]) begin
      first_cell = CELL_RIGHT;
    end else if (job_in.mask[2]) begin
      first_cell = CELL_BOTTOM;
    end else begin
      first_cell = CELL_CORNER;
    end
  end

  assign last_sub  = (sub_r == SUB_ODD_ODD);
  assign job_end   = last_sub && (higher == 4'b0000);
  assign go        = job_valid_r && (!out_valid_r || out_tready);
  assign job_ready = !job_valid_r || (go && job_end);

  // Corner samples and base position of the current cell.
  always_comb begin
    unique case (cell_r)
      CELL_INNER: begin
        sa = job_r.ul;   sb = job_r.up;  sc = job_r.left; sd = job_r.cur;
        cell_row = job_r.row - pos_t'(1);
        cell_col = job_r.col - pos_t'(1);
      end
      CELL_RIGHT: begin
        sa = job_r.up;   sb = job_r.up;  sc = job_r.cur;  sd = job_r.cur;
        cell_row = job_r.row - pos_t'(1);
        cell_col = job_r.col;
      end
      CELL_BOTTOM: begin
        sa = job_r.left; sb = job_r.cur; sc = job_r.left; sd = job_r.cur;
        cell_row = job_r.row;
        cell_col = job_r.col - pos_t'(1);
      end
      default: begin
        sa = job_r.cur;  sb = job_r.cur; sc = job_r.cur;  sd = job_r.cur;
        cell_row = job_r.row;
        cell_col = job_r.col;
      end
    endcase
  end

  assign ea = value_t'(sa);
  assign eb = value_t'(sb);
  assign ec = value_t'(sc);
  assign ed = value_t'(sd);

  // Fine value in quarter units and the step to the next fine point.
  always_comb begin
    unique case (sub_r)
      SUB_EVEN_EVEN: begin
        value   = ea <<< 2;
        row_odd = 1'b0;
        col_odd = 1'b0;
        sub_nxt = SUB_EVEN_ODD;
      end
      SUB_EVEN_ODD: begin
        value   = (ea + eb) <<< 1;
        row_odd = 1'b0;
        col_odd = 1'b1;
        sub_nxt = SUB_ODD_EVEN;
      end
      SUB_ODD_EVEN: begin
        value   = (ea + ec) <<< 1;
        row_odd = 1'b1;
        col_odd = 1'b0;
        sub_nxt = SUB_ODD_ODD;
      end
      default: begin
        value   = ea + eb + ec + ed;
        row_odd = 1'b1;
        col_odd = 1'b1;
        sub_nxt = SUB_EVEN_EVEN;
      end
    endcase
  end

  // Sequencer control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      cell_r      <= CELL_INNER;
      sub_r       <= SUB_EVEN_EVEN;
    end else begin
      if (job_load) begin
        job_valid_r <= 1'b1;
        cell_r      <= first_cell;
        sub_r       <= SUB_EVEN_EVEN;
      end else if (go && job_end) begin
        job_valid_r <= 1'b0;
      end else if (go) begin
        sub_r <= sub_nxt;
        if (last_sub) begin
          cell_r <= next_cell;
        end
      end

      if (go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Job and output payload.
  always_ff @(posedge clk) begin
    if (job_load) begin
      job_r <= job_in;
    end
    if (go) begin
      out_value_r <= value;
      out_row_r   <= fine_coord(cell_row, row_odd);
      out_col_r   <= fine_coord(cell_col, col_odd);
      out_last_r  <= job_end;
      out_frame_r <= job_end && (cell_r == CELL_CORNER);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_col_r, out_row_r, out_value_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_frame_r;

endmodule

// ===== sv/bilinear_upsample_2x.sv =====
// Top level of the streaming 2x bilinear upsampler for a square grid.
// Depends on blup2x_pkg, blup2x_row_mem, blup2x_cell_emit and the assert header.
//
//  Channel  Direction  Content
//  in_      slave      one coarse sample per transfer, raster order
//  out_     master     one fine value with its position per transfer
//  cfg_     write      coarse side length, restarts the frame
//
// A sample causes 0 to 16 results, four on average over a frame; the sequencer
// produces one fine value per cycle while the output is not stalled.
// On the way to its first result a sample passes the read stage and line buffer
// read, loaded when the sample is accepted, then the sequencer's job register
// and then the output register, and a stall can hold it at each. Reset is
// synchronous and needs no clearing pass. A stalled output holds its value and
// backs up into the input.
`timescale 1ns / 1ps
`include "bilinear_upsample_2x_assert.svh"

module bilinear_upsample_2x
  import blup2x_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // Configuration: coarse_size [9:0]
  input  logic                   cfg_wr_en,
  input  logic [CFG_W-1:0]       cfg_wr_data,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // in_tdata: sample [15:0]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // out_tdata: value_quarters [17:0], out_row [27:18], out_col [37:28], zero [39:38]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // out_tlast: run_last
  output logic                   out_tlast,
  // out_tuser: frame_done
  output logic                   out_tuser
);

  size_t      n_r;
  pos_t       in_row_r;
  pos_t       in_col_r;
  sample_t    left_r;
  sample_t    ul_r;

  logic       b_valid_r;
  sample_t    b_cur_r;
  pos_t       b_row_r;
  pos_t       b_col_r;
  logic [3:0] b_mask_r;
  logic       b_top_r;

  size_t      nm1;
  pos_t       row_cur;
  pos_t       col_cur;
  logic       in_range;
  logic       row_last;
  logic       col_last;
  logic       accept;
  logic       handoff;
  logic       job_ready;
  sample_t    cur;
  sample_t    mem_rdata;
  sample_t    up;
  logic [3:0] mask;
  cell_job_t  job;
  logic       end_odd;

  assign nm1      = n_r - size_t'(1);
  assign in_range = (size_t'(in_row_r) < n_r) && (size_t'(in_col_r) < n_r);
  assign row_cur  = in_range ? in_row_r : '0;
  assign col_cur  = in_range ? in_col_r : '0;
  assign row_last = (size_t'(row_cur) == nm1);
  assign col_last = (size_t'(col_cur) == nm1);
  assign cur      = sample_t'(in_tdata[SAMPLE_W-1:0]);

  // Cells that this sample completes.
  assign mask[0] = (row_cur != '0) && (col_cur != '0);
  assign mask[1] = (row_cur != '0) && col_last;
  assign mask[2] = row_last && (col_cur != '0);
  assign mask[3] = row_last && col_last;

  assign handoff   = b_valid_r && job_ready;
  assign in_tready = !b_valid_r || handoff;
  assign accept    = in_tvalid && in_tready;

  // Line buffer: read the column above and store the current sample.
  blup2x_row_mem u_row_mem (
    .clk     (clk),
    .en      (accept),
    .addr    (col_cur),
    .wr_data (cur),
    .rd_data (mem_rdata)
  );

  assign up = b_top_r ? sample_t'(0) : mem_rdata;

  assign job.ul   = ul_r;
  assign job.up   = up;
  assign job.left = left_r;
  assign job.cur  = b_cur_r;
  assign job.row  = b_row_r;
  assign job.col  = b_col_r;
  assign job.mask = b_mask_r;

  blup2x_cell_emit u_cell_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_load   (handoff && (b_mask_r != 4'b0000)),
    .job_in     (job),
    .job_ready  (job_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // Grid size, raster position, neighbor samples and the read stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r       <= eff_size(CFG_W'(RESET_SIZE));
      in_row_r  <= '0;
      in_col_r  <= '0;
      left_r    <= '0;
      ul_r      <= '0;
      b_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        n_r      <= eff_size(cfg_wr_data);
        in_row_r <= '0;
        in_col_r <= '0;
      end else if (accept) begin
        if (col_last) begin
          in_col_r <= '0;
          in_row_r <= row_last ? pos_t'(0) : row_cur + pos_t'(1);
        end else begin
          in_col_r <= col_cur + pos_t'(1);
          in_row_r <= row_cur;
        end
      end

      if (handoff) begin
        left_r <= b_cur_r;
        ul_r   <= up;
      end

      if (accept) begin
        b_valid_r <= 1'b1;
      end else if (handoff) begin
        b_valid_r <= 1'b0;
      end
    end
  end

  // Read stage payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      b_cur_r  <= cur;
      b_row_r  <= row_cur;
      b_col_r  <= col_cur;
      b_mask_r <= mask;
      b_top_r  <= (row_cur == '0);
    end
  end

  // The frame end must sit on an odd row and an odd column, as the last of its run.
  assign end_odd = out_tlast && out_tdata[18] && out_tdata[28];

  `BLUP2X_ASSERT_SAME(a_no_overwrite, accept, !b_valid_r || handoff, "read stage overwritten")
  `BLUP2X_ASSERT_SAME(a_pos_in_range, 1'b1, in_range, "raster position outside the grid")
  `BLUP2X_ASSERT_SAME(a_frame_end_odd, out_tvalid && out_tuser, end_odd, "bad frame end")

endmodule
